// File: sv/priority_outbox_three_lane_core_assert.svh
// Assertion macros shared by the outbox modules.
`ifndef PRIORITY_OUTBOX_THREE_LANE_CORE_ASSERT_SVH
`define PRIORITY_OUTBOX_THREE_LANE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("outbox assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define POB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("outbox assertion failed");

`endif

// File: sv/pob_pkg.sv
`timescale 1ns / 1ps

package pob_pkg;

    // Default ring depths.
    localparam int RESP_DEPTH_DEF = 16;
    localparam int CHAT_DEPTH_DEF = 16;

    // Field widths.
    localparam int ACT_W    = 3;
    localparam int HANDLE_W = 32;
    localparam int LENGTH_W = 16;
    localparam int LANE_W   = 2;
    localparam int DROPS_W  = 32;
    localparam int ENTRY_W  = HANDLE_W + LENGTH_W;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_PUSH_RESP  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_STATE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PUSH_CHAT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP        = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DROP_ROOM  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLOSE      = 3'd5;

    // Lane codes of a popped word.
    localparam logic [LANE_W-1:0] LANE_RESP  = 2'd0;
    localparam logic [LANE_W-1:0] LANE_CHAT  = 2'd1;
    localparam logic [LANE_W-1:0] LANE_STATE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mem_pop;
    } dp_stat_t;

endpackage

// File: sv/priority_outbox_three_lane_core.sv
`timescale 1ns / 1ps

// Three-lane priority outbox. A command word is taken on a rising edge with start high
// and busy low; its result appears on the result ports, marked by done, which is high for
// exactly one cycle, and must be captured then because the receiver cannot stall the
// block. Pushes, drop-room, close, state-lane pops and empty pops go through the execute
// state to the done strobe; a pop served from a response or chat ring adds a read state,
// for the registered read port of the ring memory. busy stays high until the result is
// registered, so a new word may be started in the same cycle that done is high.
module priority_outbox_three_lane_core #(
    parameter int RESP_DEPTH = pob_pkg::RESP_DEPTH_DEF,
    parameter int CHAT_DEPTH = pob_pkg::CHAT_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic [pob_pkg::ACT_W-1:0]     action,
    input  logic [pob_pkg::HANDLE_W-1:0]  handle,
    input  logic [pob_pkg::LENGTH_W-1:0]  length,
    output logic                          status,
    output logic                          out_valid,
    output logic [pob_pkg::HANDLE_W-1:0]  out_handle,
    output logic [pob_pkg::LENGTH_W-1:0]  out_length,
    output logic [pob_pkg::LANE_W-1:0]    out_lane,
    output logic                          idle,
    output logic                          overflowed,
    output logic                          closed_flag,
    output logic [pob_pkg::DROPS_W-1:0]   chat_drops
);

    pob_pkg::ctrl_cmd_t cmd;
    pob_pkg::dp_stat_t  stat;

    // Sequencer.
    pob_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Lane state, ring memories and result registers.
    pob_dp #(
        .RESP_DEPTH (RESP_DEPTH),
        .CHAT_DEPTH (CHAT_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .handle      (handle),
        .length      (length),
        .status      (status),
        .out_valid   (out_valid),
        .out_handle  (out_handle),
        .out_length  (out_length),
        .out_lane    (out_lane),
        .idle        (idle),
        .overflowed  (overflowed),
        .closed_flag (closed_flag),
        .chat_drops  (chat_drops)
    );

endmodule

// File: sv/pob_ram.sv
`timescale 1ns / 1ps

module pob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/pob_ctrl.sv
`timescale 1ns / 1ps
`include "priority_outbox_three_lane_core_assert.svh"

module pob_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output pob_pkg::ctrl_cmd_t cmd,
    input  pob_pkg::dp_stat_t  stat
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Next-state logic and command decode.
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.fetch   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.mem_pop)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.fetch  = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and strobe registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // A done strobe is always followed by done low, and a read always follows an execute.
    `POB_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `POB_ASSERT_IMPLIES(a_read_after_exec, clk, rst_n, state_reg == S_READ,
                        $past(state_reg == S_EXEC))

endmodule

// File: sv/pob_dp.sv
`timescale 1ns / 1ps
`include "priority_outbox_three_lane_core_assert.svh"

module pob_dp #(
    parameter int RESP_DEPTH = pob_pkg::RESP_DEPTH_DEF,
    parameter int CHAT_DEPTH = pob_pkg::CHAT_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pob_pkg::ctrl_cmd_t            cmd,
    output pob_pkg::dp_stat_t             stat,
    input  logic [pob_pkg::ACT_W-1:0]     action,
    input  logic [pob_pkg::HANDLE_W-1:0]  handle,
    input  logic [pob_pkg::LENGTH_W-1:0]  length,
    output logic                          status,
    output logic                          out_valid,
    output logic [pob_pkg::HANDLE_W-1:0]  out_handle,
    output logic [pob_pkg::LENGTH_W-1:0]  out_length,
    output logic [pob_pkg::LANE_W-1:0]    out_lane,
    output logic                          idle,
    output logic                          overflowed,
    output logic                          closed_flag,
    output logic [pob_pkg::DROPS_W-1:0]   chat_drops
);

    localparam int RPW = (RESP_DEPTH > 1) ? $clog2(RESP_DEPTH) : 1;
    localparam int RCW = $clog2(RESP_DEPTH + 1);
    localparam int RSW = RCW + 1;
    localparam int CPW = (CHAT_DEPTH > 1) ? $clog2(CHAT_DEPTH) : 1;
    localparam int CCW = $clog2(CHAT_DEPTH + 1);
    localparam int CSW = CCW + 1;

    localparam logic [RPW-1:0] RESP_LAST = RPW'(RESP_DEPTH - 1);
    localparam logic [RCW-1:0] RESP_FULL = RCW'(RESP_DEPTH);
    localparam logic [RSW-1:0] RESP_MOD  = RSW'(RESP_DEPTH);
    localparam logic [CPW-1:0] CHAT_LAST = CPW'(CHAT_DEPTH - 1);
    localparam logic [CCW-1:0] CHAT_FULL = CCW'(CHAT_DEPTH);
    localparam logic [CSW-1:0] CHAT_MOD  = CSW'(CHAT_DEPTH);

    // Captured command word.
    logic [pob_pkg::ACT_W-1:0]    act_reg;
    logic [pob_pkg::HANDLE_W-1:0] hnd_reg;
    logic [pob_pkg::LENGTH_W-1:0] len_reg;

    // Lane state.
    logic [RPW-1:0]               resp_head_reg, resp_head_next;
    logic [RCW-1:0]               resp_count_reg, resp_count_next;
    logic [CPW-1:0]               chat_head_reg, chat_head_next;
    logic [CCW-1:0]               chat_count_reg, chat_count_next;
    logic [pob_pkg::DROPS_W-1:0]  drops_reg, drops_next;
    logic [pob_pkg::HANDLE_W-1:0] mb_handle_reg, mb_handle_next;
    logic [pob_pkg::LENGTH_W-1:0] mb_length_reg, mb_length_next;
    logic                         mb_pending_reg, mb_pending_next;
    logic                         overflow_reg, overflow_next;
    logic                         closed_reg, closed_next;

    // Result registers.
    logic                         status_reg, status_next;
    logic                         out_valid_reg, out_valid_next;
    logic [pob_pkg::HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [pob_pkg::LENGTH_W-1:0] out_length_reg, out_length_next;
    logic [pob_pkg::LANE_W-1:0]   out_lane_reg, out_lane_next;

    // Ring memory ports.
    logic                        resp_we, resp_re, chat_we, chat_re;
    logic [RPW-1:0]              resp_tail;
    logic [CPW-1:0]              chat_tail;
    logic [pob_pkg::ENTRY_W-1:0] resp_rdata, chat_rdata;
    logic [RSW-1:0]              resp_sum;
    logic [CSW-1:0]              chat_sum;
    logic [RPW-1:0]              resp_head_inc;
    logic [CPW-1:0]              chat_head_inc;
    logic                        resp_full, chat_full, push_ok, is_pop;

    // Capture the command word on acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            hnd_reg <= handle;
            len_reg <= length;
        end
    end

    // Ring pointer arithmetic: tail is head plus count, wrapped once.
    always_comb
    begin
        resp_full     = (resp_count_reg == RESP_FULL);
        chat_full     = (chat_count_reg == CHAT_FULL);
        resp_sum      = RSW'(resp_head_reg) + RSW'(resp_count_reg);
        chat_sum      = CSW'(chat_head_reg) + CSW'(chat_count_reg);
        if (resp_sum >= RESP_MOD)
        begin
            resp_sum = resp_sum - RESP_MOD;
        end
        if (chat_sum >= CHAT_MOD)
        begin
            chat_sum = chat_sum - CHAT_MOD;
        end
        resp_tail     = resp_sum[RPW-1:0];
        // A full chat ring overwrites its oldest entry, which sits at the head.
        chat_tail     = chat_full ? chat_head_reg : chat_sum[CPW-1:0];
        resp_head_inc = (resp_head_reg == RESP_LAST) ? '0 : resp_head_reg + 1'b1;
        chat_head_inc = (chat_head_reg == CHAT_LAST) ? '0 : chat_head_reg + 1'b1;
        push_ok       = (hnd_reg != '0) && !closed_reg;
        is_pop        = (act_reg == pob_pkg::ACT_POP);
    end

    assign stat.mem_pop = is_pop && ((resp_count_reg != '0) || (chat_count_reg != '0));

    // Execute one command word.
    always_comb
    begin
        resp_head_next  = resp_head_reg;
        resp_count_next = resp_count_reg;
        chat_head_next  = chat_head_reg;
        chat_count_next = chat_count_reg;
        drops_next      = drops_reg;
        mb_handle_next  = mb_handle_reg;
        mb_length_next  = mb_length_reg;
        mb_pending_next = mb_pending_reg;
        overflow_next   = overflow_reg;
        closed_next     = closed_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_handle_next = out_handle_reg;
        out_length_next = out_length_reg;
        out_lane_next   = out_lane_reg;
        resp_we         = 1'b0;
        chat_we         = 1'b0;
        resp_re         = 1'b0;
        chat_re         = 1'b0;

        if (cmd.exec)
        begin
            status_next     = 1'b1;
            out_valid_next  = 1'b0;
            out_handle_next = '0;
            out_length_next = '0;
            out_lane_next   = pob_pkg::LANE_RESP;
            unique case (act_reg)
                pob_pkg::ACT_PUSH_RESP:
                begin
                    if (push_ok)
                    begin
                        if (resp_full)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            resp_we         = 1'b1;
                            resp_count_next = resp_count_reg + 1'b1;
                            status_next     = 1'b0;
                        end
                    end
                end
                pob_pkg::ACT_PUSH_STATE:
                begin
                    if (push_ok)
                    begin
                        mb_handle_next  = hnd_reg;
                        mb_length_next  = len_reg;
                        mb_pending_next = 1'b1;
                        status_next     = 1'b0;
                    end
                end
                pob_pkg::ACT_PUSH_CHAT:
                begin
                    if (push_ok)
                    begin
                        chat_we     = 1'b1;
                        status_next = 1'b0;
                        if (chat_full)
                        begin
                            chat_head_next = chat_head_inc;
                            if (drops_reg != '1)
                            begin
                                drops_next = drops_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            chat_count_next = chat_count_reg + 1'b1;
                        end
                    end
                end
                pob_pkg::ACT_POP:
                begin
                    // Strict priority: response, then chat, then state.
                    if (resp_count_reg != '0)
                    begin
                        resp_re         = 1'b1;
                        resp_head_next  = resp_head_inc;
                        resp_count_next = resp_count_reg - 1'b1;
                        status_next     = 1'b0;
                        out_valid_next  = 1'b1;
                        out_lane_next   = pob_pkg::LANE_RESP;
                    end
                    else if (chat_count_reg != '0)
                    begin
                        chat_re         = 1'b1;
                        chat_head_next  = chat_head_inc;
                        chat_count_next = chat_count_reg - 1'b1;
                        status_next     = 1'b0;
                        out_valid_next  = 1'b1;
                        out_lane_next   = pob_pkg::LANE_CHAT;
                    end
                    else if (mb_pending_reg)
                    begin
                        out_handle_next = mb_handle_reg;
                        out_length_next = mb_length_reg;
                        out_lane_next   = pob_pkg::LANE_STATE;
                        status_next     = 1'b0;
                        out_valid_next  = 1'b1;
                        mb_handle_next  = '0;
                        mb_length_next  = '0;
                        mb_pending_next = 1'b0;
                    end
                end
                pob_pkg::ACT_DROP_ROOM:
                begin
                    chat_head_next  = '0;
                    chat_count_next = '0;
                    mb_handle_next  = '0;
                    mb_length_next  = '0;
                    mb_pending_next = 1'b0;
                    status_next     = 1'b0;
                end
                pob_pkg::ACT_CLOSE:
                begin
                    closed_next     = 1'b1;
                    resp_head_next  = '0;
                    resp_count_next = '0;
                    chat_head_next  = '0;
                    chat_count_next = '0;
                    mb_handle_next  = '0;
                    mb_length_next  = '0;
                    mb_pending_next = 1'b0;
                    status_next     = 1'b0;
                end
                default:
                begin
                    status_next = 1'b1;
                end
            endcase
        end
        else if (cmd.fetch)
        begin
            // Ring data comes from the registered read port, read during the execute state.
            if (out_lane_reg == pob_pkg::LANE_RESP)
            begin
                out_handle_next = resp_rdata[pob_pkg::ENTRY_W-1:pob_pkg::LENGTH_W];
                out_length_next = resp_rdata[pob_pkg::LENGTH_W-1:0];
            end
            else
            begin
                out_handle_next = chat_rdata[pob_pkg::ENTRY_W-1:pob_pkg::LENGTH_W];
                out_length_next = chat_rdata[pob_pkg::LENGTH_W-1:0];
            end
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_head_reg  <= '0;
            resp_count_reg <= '0;
            chat_head_reg  <= '0;
            chat_count_reg <= '0;
            drops_reg      <= '0;
            mb_handle_reg  <= '0;
            mb_length_reg  <= '0;
            mb_pending_reg <= 1'b0;
            overflow_reg   <= 1'b0;
            closed_reg     <= 1'b0;
            status_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_handle_reg <= '0;
            out_length_reg <= '0;
            out_lane_reg   <= '0;
        end
        else
        begin
            resp_head_reg  <= resp_head_next;
            resp_count_reg <= resp_count_next;
            chat_head_reg  <= chat_head_next;
            chat_count_reg <= chat_count_next;
            drops_reg      <= drops_next;
            mb_handle_reg  <= mb_handle_next;
            mb_length_reg  <= mb_length_next;
            mb_pending_reg <= mb_pending_next;
            overflow_reg   <= overflow_next;
            closed_reg     <= closed_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_handle_reg <= out_handle_next;
            out_length_reg <= out_length_next;
            out_lane_reg   <= out_lane_next;
        end
    end

    // Response ring storage.
    pob_ram #(
        .WIDTH (pob_pkg::ENTRY_W),
        .DEPTH (RESP_DEPTH)
    ) u_resp_ram (
        .clk   (clk),
        .we    (resp_we),
        .waddr (resp_tail),
        .wdata ({hnd_reg, len_reg}),
        .re    (resp_re),
        .raddr (resp_head_reg),
        .rdata (resp_rdata)
    );

    // Chat ring storage.
    pob_ram #(
        .WIDTH (pob_pkg::ENTRY_W),
        .DEPTH (CHAT_DEPTH)
    ) u_chat_ram (
        .clk   (clk),
        .we    (chat_we),
        .waddr (chat_tail),
        .wdata ({hnd_reg, len_reg}),
        .re    (chat_re),
        .raddr (chat_head_reg),
        .rdata (chat_rdata)
    );

    assign status      = status_reg;
    assign out_valid   = out_valid_reg;
    assign out_handle  = out_handle_reg;
    assign out_length  = out_length_reg;
    assign out_lane    = out_lane_reg;
    assign idle        = (resp_count_reg == '0) && (chat_count_reg == '0) && !mb_pending_reg;
    assign overflowed  = overflow_reg;
    assign closed_flag = closed_reg;
    assign chat_drops  = drops_reg;

    // Counts stay within the rings, and a closed outbox holds nothing.
    `POB_ASSERT_IMPLIES(a_resp_bound, clk, rst_n, 1'b1, resp_count_reg <= RESP_FULL)
    `POB_ASSERT_IMPLIES(a_chat_bound, clk, rst_n, 1'b1, chat_count_reg <= CHAT_FULL)
    `POB_ASSERT_IMPLIES(a_closed_empty, clk, rst_n, closed_reg,
                        (resp_count_reg == '0) && (chat_count_reg == '0) && !mb_pending_reg)

endmodule
